[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define VDPHP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, off while reset is high
`define VDPHP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Next-cycle implication that also watches reset itself
`define VDPHP_ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

[rtl/vdphp_pkg.sv]
// ---------------------------------------------------------------------------
// vdphp_pkg
// Types, codes and address helpers of the video display processor host port.
// ---------------------------------------------------------------------------
`default_nettype none

package vdphp_pkg;

   localparam int VRAM_BYTES    = 16384;
   localparam int NUM_CTRL_REGS = 8;
   localparam int ADDR_W        = $clog2(VRAM_BYTES);

   // Host operations
   typedef enum logic [2:0] {
      OP_WRITE_DATA  = 3'd0,
      OP_WRITE_CTRL  = 3'd1,
      OP_READ_DATA   = 3'd2,
      OP_READ_STATUS = 3'd3,
      OP_LOAD_STATUS = 3'd4
   } opcode_type;

   // Register number (bits 13..8 of the control word) that holds the 16K mode bit
   localparam logic [5:0] CTRL_REG_MODE    = 6'd1;
   localparam int         MODE_BIT         = 7;
   // Status flags kept on a status read
   localparam logic [7:0] STATUS_KEEP_MASK = 8'h1f;

   // Configuration register indexes (word addresses)
   localparam logic CSR_FORCE_FULL = 1'b0;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_in;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
   } rsp_type;

   // At most one VRAM access per host beat
   typedef struct packed {
      logic              read_en;
      logic              write_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } vram_req_type;

   // 4K row/column remap of a 14-bit host address
   function automatic logic [ADDR_W-1:0] remap_4k(logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] p;
      p        = '0;
      p[5:0]   = a[5:0];
      // address bit 12 folds onto bit 5; bit 6 stays clear
      p[5]     = a[5] | a[12];
      p[12:7]  = a[11:6];
      p[13]    = a[13];
      return p;
   endfunction

endpackage

`default_nettype wire

[rtl/video_display_processor_host_port.sv]
// ---------------------------------------------------------------------------
// video_display_processor_host_port
// Host port of a video display processor: address and register loading,
// prefetched VRAM reads, VRAM writes and status access.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   vdphp_pkg::req_type (opcode, data_in)
//   rsp      out        rsp_valid/stall   vdphp_pkg::rsp_type (read_data, read_valid)
//   csr      in/out     APB psel/penable  force_full_addressing at byte 0
//
// One beat per cycle while req_stall is low; each beat makes at most one VRAM access on
// the single port, and a prefetch refill is forwarded from the read register to the next beat.
// Each result is registered in the result queue before it leaves on rsp.
// Reset is synchronous; VRAM is not cleared.
// The result queue holds two beats; req_stall is high while both are full.
// ---------------------------------------------------------------------------
`default_nettype none

module video_display_processor_host_port (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  vdphp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output vdphp_pkg::rsp_type rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic                    accept;
   logic                    full;
   logic                    force_full_ff, force_full_in;
   logic                    csr_write;
   logic [7:0]              mem_rdata;
   vdphp_pkg::vram_req_type mem_req;
   vdphp_pkg::rsp_type      result;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   // Configuration register
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      force_full_in = force_full_ff;
      if (csr_write && (paddr[2] == vdphp_pkg::CSR_FORCE_FULL) && (paddr[1:0] == 2'b00)) begin
         force_full_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if ((paddr[2] == vdphp_pkg::CSR_FORCE_FULL) && (paddr[1:0] == 2'b00)) begin
         prdata = {31'b0, force_full_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         force_full_ff <= 1'b0;
      end else begin
         force_full_ff <= force_full_in;
      end
   end

   vdphp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .force_full (force_full_ff),
      .mem_rdata  (mem_rdata),
      .mem_req    (mem_req),
      .result     (result)
   );

   vdphp_vram u_vram (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   vdphp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/vdphp_vram.sv]
// ---------------------------------------------------------------------------
// vdphp_vram
// Single-port 16K x 8 video memory with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module vdphp_vram (
   input  logic                   clock,
   input  vdphp_pkg::vram_req_type mem_req,
   output logic [7:0]             mem_rdata
);

   logic [7:0] vram_ff [vdphp_pkg::VRAM_BYTES];
   logic [7:0] rdata_ff;

   // Write or read one byte per cycle
   always_ff @(posedge clock) begin
      if (mem_req.write_en) begin
         vram_ff[mem_req.addr] <= mem_req.wdata;
      end else if (mem_req.read_en) begin
         rdata_ff <= vram_ff[mem_req.addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

[rtl/vdphp_ctrl.sv]
// ---------------------------------------------------------------------------
// vdphp_ctrl
// Address counter, byte flip-flop, prefetch latch, status and mode state;
// decodes each host beat into at most one VRAM access and one result.
// ---------------------------------------------------------------------------
`default_nettype none

module vdphp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  vdphp_pkg::req_type      req,
   input  logic                    force_full,
   input  logic [7:0]              mem_rdata,
   output vdphp_pkg::vram_req_type mem_req,
   output vdphp_pkg::rsp_type      result
);

   localparam int AW = vdphp_pkg::ADDR_W;

   logic [AW-1:0] addr_ff, addr_in;
   logic          byte_pend_ff, byte_pend_in;
   logic [7:0]    prefetch_ff, prefetch_in;
   logic          refill_ff, refill_in;
   logic [7:0]    status_ff, status_in;
   logic          mode16k_ff, mode16k_in;

   logic [7:0]    prefetch_cur;
   logic [AW-1:0] word_addr;
   logic [AW-1:0] src_addr;
   logic          second_ctrl;

   // Refill data lands in the cycle after its read: forward it
   assign prefetch_cur = refill_ff ? mem_rdata : prefetch_ff;
   assign word_addr    = {req.data_in[5:0], addr_ff[7:0]};
   assign second_ctrl  = (req.opcode == vdphp_pkg::OP_WRITE_CTRL) && byte_pend_ff;
   assign src_addr     = second_ctrl ? word_addr : addr_ff;

   // Decode the beat
   always_comb begin
      addr_in           = addr_ff;
      byte_pend_in      = byte_pend_ff;
      prefetch_in       = prefetch_cur;
      refill_in         = 1'b0;
      status_in         = status_ff;
      mode16k_in        = mode16k_ff;
      result            = '0;
      mem_req.read_en   = 1'b0;
      mem_req.write_en  = 1'b0;
      mem_req.wdata     = req.data_in;
      mem_req.addr      = (force_full || mode16k_ff) ? src_addr
                                                     : vdphp_pkg::remap_4k(src_addr);
      if (accept) begin
         unique case (req.opcode)
            vdphp_pkg::OP_WRITE_DATA: begin
               byte_pend_in     = 1'b0;
               mem_req.write_en = 1'b1;
               prefetch_in      = req.data_in;
               addr_in          = addr_ff + AW'(1);
            end
            vdphp_pkg::OP_WRITE_CTRL: begin
               if (!byte_pend_ff) begin
                  addr_in      = {addr_ff[AW-1:8], req.data_in};
                  byte_pend_in = 1'b1;
               end else begin
                  byte_pend_in = 1'b0;
                  addr_in      = word_addr;
                  // Register write; only the mode bit of register 1 is kept here
                  if (req.data_in[7] && (req.data_in[5:0] == vdphp_pkg::CTRL_REG_MODE)) begin
                     mode16k_in = addr_ff[vdphp_pkg::MODE_BIT];
                  end
                  // Read setup: prefetch and advance
                  if (req.data_in[7:6] == 2'b00) begin
                     mem_req.read_en = 1'b1;
                     refill_in       = 1'b1;
                     addr_in         = word_addr + AW'(1);
                  end
               end
            end
            vdphp_pkg::OP_READ_DATA: begin
               byte_pend_in      = 1'b0;
               result.read_data  = prefetch_cur;
               result.read_valid = 1'b1;
               mem_req.read_en   = 1'b1;
               refill_in         = 1'b1;
               addr_in           = addr_ff + AW'(1);
            end
            vdphp_pkg::OP_READ_STATUS: begin
               byte_pend_in      = 1'b0;
               result.read_data  = status_ff;
               result.read_valid = 1'b1;
               status_in         = status_ff & vdphp_pkg::STATUS_KEEP_MASK;
            end
            vdphp_pkg::OP_LOAD_STATUS: begin
               status_in = req.data_in;
            end
            default: begin
            end
         endcase
      end
   end

   // Update state
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         byte_pend_ff <= 1'b0;
         prefetch_ff  <= '0;
         refill_ff    <= 1'b0;
         status_ff    <= '0;
         mode16k_ff   <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         byte_pend_ff <= byte_pend_in;
         prefetch_ff  <= prefetch_in;
         refill_ff    <= refill_in;
         status_ff    <= status_in;
         mode16k_ff   <= mode16k_in;
      end
   end

endmodule

`default_nettype wire

[rtl/vdphp_rsp_queue.sv]
// ---------------------------------------------------------------------------
// vdphp_rsp_queue
// Two-entry result queue: output register plus skid entry.
// ---------------------------------------------------------------------------
`default_nettype none

module vdphp_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vdphp_pkg::rsp_type push_data,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output vdphp_pkg::rsp_type rsp_data
);

   logic [1:0]         count_ff, count_in;
   vdphp_pkg::rsp_type head_ff, head_in;
   vdphp_pkg::rsp_type skid_ff, skid_in;
   logic               pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;

   // Advance head and skid entries
   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (push && ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop))) begin
         head_in = push_data;
      end else if ((count_ff == 2'd2) && pop) begin
         head_in = skid_ff;
      end
      if (push && (count_ff == 2'd1) && !pop) begin
         skid_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

[rtl/vdphp_checker.sv]
// ---------------------------------------------------------------------------
// vdphp_checker
// Port-level checks of the host port, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vdphp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  vdphp_pkg::rsp_type rsp_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               pready
);

   // Non-read beats return zero data
   `VDPHP_ASSERT_IMPL(a_zero_data, clock, reset, rsp_valid && !rsp_data.read_valid, rsp_data.read_data == 8'd0)
   // Input side only waits on a waiting result
   `VDPHP_ASSERT_IMPL(a_stall_cause, clock, reset, req_stall, rsp_valid)
   // Reset empties the result queue
   `VDPHP_ASSERT_NEXT_ALL(a_reset_empty, clock, reset, !rsp_valid && !req_stall)
   // A stalled result stays
   `VDPHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // Configuration port never waits
   `VDPHP_ASSERT_IMPL(a_pready, clock, reset, req_valid || !req_valid, pready)

endmodule

bind video_display_processor_host_port vdphp_checker u_vdphp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .pready    (pready)
);

`default_nettype wire

[bench/video_display_processor_host_port_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// video_display_processor_host_port_checker
// Watches the request, result and register channels of the host port. It
// keeps its own copy of VRAM, the address counter, the byte flip-flop, the
// read-ahead byte, the control and status registers, and the addressing
// mode, and compares every result beat with the oldest expected one.
// ---------------------------------------------------------------------------

module video_display_processor_host_port_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  vdphp_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  vdphp_pkg::rsp_type rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 mismatch_count,
   output int                 results_due,
   output int                 reads_compared
);

   localparam int         MAX_REPORTS     = 10;
   localparam int         AW              = vdphp_pkg::ADDR_W;
   localparam logic [2:0] FORCE_FULL_ADDR = {vdphp_pkg::CSR_FORCE_FULL, 2'b00};

   logic [7:0]         vram_img [vdphp_pkg::VRAM_BYTES];
   logic [AW-1:0]      host_addr;
   logic               low_byte_held;
   logic [7:0]         read_ahead;
   logic [7:0]         ctrl_reg [vdphp_pkg::NUM_CTRL_REGS];
   logic [7:0]         status_byte;
   logic               force_linear;
   vdphp_pkg::rsp_type read_back_q [$];

   // Map a host address onto VRAM: linear, or the 4K row/column layout
   function automatic logic [AW-1:0] vram_index(logic [AW-1:0] a);
      if (force_linear || ctrl_reg[vdphp_pkg::CTRL_REG_MODE[2:0]][vdphp_pkg::MODE_BIT])
         return a;
      return {a[13], a[11:6], 1'b0, a[5] | a[12], a[4:0]};
   endfunction

   // Apply one host beat to the local state and return what it reads back
   function automatic vdphp_pkg::rsp_type host_access(vdphp_pkg::req_type beat);
      vdphp_pkg::rsp_type res;
      logic [15:0]        word;
      res = '0;
      case (beat.opcode)
         vdphp_pkg::OP_WRITE_DATA: begin
            low_byte_held = 1'b0;
            vram_img[vram_index(host_addr)] = beat.data_in;
            read_ahead = beat.data_in;
            host_addr = host_addr + 1'b1;
         end
         vdphp_pkg::OP_WRITE_CTRL: begin
            if (!low_byte_held) begin
               host_addr[7:0] = beat.data_in;
               low_byte_held = 1'b1;
            end else begin
               word = {beat.data_in, host_addr[7:0]};
               low_byte_held = 1'b0;
               host_addr = word[13:0];
               // register load; numbers past the bank are dropped
               if (word[15] && word[13:8] < vdphp_pkg::NUM_CTRL_REGS)
                  ctrl_reg[word[10:8]] = word[7:0];
               // read setup: fill the read-ahead byte and step on
               if (word[15:14] == 2'b00) begin
                  read_ahead = vram_img[vram_index(host_addr)];
                  host_addr = host_addr + 1'b1;
               end
            end
         end
         vdphp_pkg::OP_READ_DATA: begin
            low_byte_held = 1'b0;
            res.read_data = read_ahead;
            res.read_valid = 1'b1;
            read_ahead = vram_img[vram_index(host_addr)];
            host_addr = host_addr + 1'b1;
         end
         vdphp_pkg::OP_READ_STATUS: begin
            low_byte_held = 1'b0;
            res.read_data = status_byte;
            res.read_valid = 1'b1;
            status_byte = status_byte & vdphp_pkg::STATUS_KEEP_MASK;
         end
         vdphp_pkg::OP_LOAD_STATUS: begin
            status_byte = beat.data_in;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input vdphp_pkg::rsp_type want,
                                  input vdphp_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: read_data exp %02h got %02h, read_valid exp %0b got %0b",
                  $time, what, want.read_data, got.read_data, want.read_valid,
                  got.read_valid);
   endtask

   always @(posedge clock) begin : watch
      vdphp_pkg::rsp_type want;
      if (reset) begin
         host_addr = '0;
         low_byte_held = 1'b0;
         read_ahead = '0;
         status_byte = '0;
         force_linear = 1'b0;
         for (int i = 0; i < vdphp_pkg::NUM_CTRL_REGS; i++)
            ctrl_reg[i] = '0;
         read_back_q.delete();
         mismatch_count = 0;
         reads_compared = 0;
      end else begin
         // track the addressing mode register
         if (psel && penable && pwrite && pready && paddr == FORCE_FULL_ADDR)
            force_linear = pwdata[0];
         // compare the result beat first: it can never belong to this edge's request
         if (rsp_valid && !rsp_stall) begin
            if (read_back_q.size() == 0) begin
               report_mismatch("result with nothing due", '0, rsp_data);
            end else begin
               want = read_back_q.pop_front();
               if (rsp_data.read_valid) reads_compared++;
               if (rsp_data.read_data !== want.read_data ||
                   rsp_data.read_valid !== want.read_valid)
                  report_mismatch("result mismatch", want, rsp_data);
            end
         end
         // predict the request beat
         if (req_valid && !req_stall)
            read_back_q.push_back(host_access(req_data));
      end
      results_due = read_back_q.size();
   end

endmodule

[bench/video_display_processor_host_port_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// video_display_processor_host_port_test
// Drives host beats and addressing-mode writes into the host port: a short
// directed run through status access, address setup, read-ahead, register
// loads and address wrap, then random write and read bursts over three idle
// mixes. The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------

module video_display_processor_host_port_test;

   localparam int         AW              = vdphp_pkg::ADDR_W;
   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         HOLD_OFF_CYCLES = 40;
   localparam int         DRAIN_CYCLES    = 8;
   localparam int         PHASE_BEATS     = 520;
   localparam logic [2:0] OP_SPARE_LAST   = 3'd7;
   localparam logic [2:0] FORCE_FULL_ADDR = {vdphp_pkg::CSR_FORCE_FULL, 2'b00};

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   vdphp_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   vdphp_pkg::rsp_type rsp_data;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   int mismatch_count;
   int results_due;
   int reads_compared;

   int   send_gap_pct;
   int   rsp_stall_pct;
   int   beats_sent;
   int   quiet_cycles;
   logic hold_off_req;

   // Address tracking that keeps reads off VRAM bytes never written
   logic [AW-1:0] addr_track;
   logic          low_held_track;
   logic          wide_track;
   logic          force_track;
   logic [AW-1:0] last_fill_base;
   bit            vram_filled [vdphp_pkg::VRAM_BYTES];

   video_display_processor_host_port u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   video_display_processor_host_port_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .results_due    (results_due),
      .reads_compared (reads_compared)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: random stall, or one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req <= 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a beat", quiet_cycles);
         $display("video_display_processor_host_port_test NOT OK");
         $finish;
      end
   end

   function automatic logic [AW-1:0] track_index(logic [AW-1:0] a);
      if (force_track || wide_track)
         return a;
      return {a[13], a[11:6], 1'b0, a[5] | a[12], a[4:0]};
   endfunction

   // Offer one beat and wait for it to be taken; called and returns at a falling edge
   task automatic send_beat(input logic [2:0] op, input logic [7:0] value);
      vdphp_pkg::req_type beat;
      logic [15:0]        word;
      beat.opcode = op;
      beat.data_in = value;
      // turn a read of an unwritten byte into a write
      if (beat.opcode == vdphp_pkg::OP_READ_DATA && !vram_filled[track_index(addr_track)])
         beat.opcode = vdphp_pkg::OP_WRITE_DATA;
      case (beat.opcode)
         vdphp_pkg::OP_WRITE_DATA, vdphp_pkg::OP_READ_DATA: begin
            low_held_track = 1'b0;
            vram_filled[track_index(addr_track)] = 1'b1;
            addr_track = addr_track + 1'b1;
         end
         vdphp_pkg::OP_WRITE_CTRL: begin
            if (!low_held_track) begin
               addr_track[7:0] = beat.data_in;
               low_held_track = 1'b1;
            end else begin
               word = {beat.data_in, addr_track[7:0]};
               // drop the read setup where the read-ahead would hit an unwritten byte
               if (word[15:14] == 2'b00 && !vram_filled[track_index(word[13:0])]) begin
                  beat.data_in[6] = 1'b1;
                  word[14] = 1'b1;
               end
               low_held_track = 1'b0;
               addr_track = word[13:0];
               if (word[15] && word[13:8] == vdphp_pkg::CTRL_REG_MODE)
                  wide_track = word[vdphp_pkg::MODE_BIT];
               if (word[15:14] == 2'b00)
                  addr_track = addr_track + 1'b1;
            end
         end
         vdphp_pkg::OP_READ_STATUS: low_held_track = 1'b0;
         default: begin
         end
      endcase
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // Stop offering and wait until every expected result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // One random sequence: register load, write burst, read burst, status or noise
   task automatic random_sequence();
      int            kind;
      logic [AW-1:0] base;
      logic [5:0]    reg_no;
      kind = $urandom_range(99);
      base = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(511));
      if (kind < 12) begin
         // often the mode register, now and then a number past the bank
         reg_no = ($urandom_range(2) == 0) ? vdphp_pkg::CTRL_REG_MODE :
                  ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(7));
         send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'($urandom));
         send_beat(vdphp_pkg::OP_WRITE_CTRL, {1'b1, 1'($urandom), reg_no});
      end else if (kind < 45) begin
         last_fill_base = base;
         send_beat(vdphp_pkg::OP_WRITE_CTRL, base[7:0]);
         send_beat(vdphp_pkg::OP_WRITE_CTRL, {2'b01, base[13:8]});
         repeat ($urandom_range(1, 12)) send_beat(vdphp_pkg::OP_WRITE_DATA, 8'($urandom));
      end else if (kind < 80) begin
         // read back over the last written stretch half the time
         if ($urandom_range(1) == 0)
            base = last_fill_base;
         send_beat(vdphp_pkg::OP_WRITE_CTRL, base[7:0]);
         send_beat(vdphp_pkg::OP_WRITE_CTRL, {2'b00, base[13:8]});
         repeat ($urandom_range(1, 12))
            send_beat(($urandom_range(9) == 0) ? vdphp_pkg::OP_READ_STATUS
                                               : vdphp_pkg::OP_READ_DATA,
                      8'($urandom));
      end else if (kind < 90) begin
         send_beat(vdphp_pkg::OP_LOAD_STATUS, 8'($urandom));
         repeat ($urandom_range(1, 2)) send_beat(vdphp_pkg::OP_READ_STATUS, 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 4)) send_beat(3'($urandom), 8'($urandom));
      end
   endtask

   // One idle mix and addressing setting, with one hold-off and one full pause
   task automatic run_phase(input int beats, input int gap_pct, input int stall_pct,
                            input logic linear);
      int first;
      bit held;
      bit paused;
      held = 1'b0;
      paused = 1'b0;
      wait_drained();
      csr_write(FORCE_FULL_ADDR, {31'd0, linear});
      force_track = linear;
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      first = beats_sent;
      while (beats_sent - first < beats) begin
         if (!held && beats_sent - first >= beats / 3) begin
            hold_off_req <= 1'b1;
            held = 1'b1;
         end
         if (!paused && beats_sent - first >= 2 * beats / 3) begin
            wait_drained();
            paused = 1'b1;
         end
         random_sequence();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      hold_off_req = 1'b0;
      send_gap_pct = 18;
      rsp_stall_pct = 72;
      beats_sent = 0;
      addr_track = '0;
      low_held_track = 1'b0;
      wide_track = 1'b0;
      force_track = 1'b0;
      last_fill_base = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_write(FORCE_FULL_ADDR, 32'd0);

      // status load, then reads that clear the top three flags
      send_beat(vdphp_pkg::OP_LOAD_STATUS, 8'hff);
      send_beat(vdphp_pkg::OP_READ_STATUS, 8'h00);
      send_beat(vdphp_pkg::OP_READ_STATUS, 8'h00);
      // write setup at address zero, then extreme bytes
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h00);
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h40);
      send_beat(vdphp_pkg::OP_WRITE_DATA, 8'h00);
      send_beat(vdphp_pkg::OP_WRITE_DATA, 8'hff);
      send_beat(vdphp_pkg::OP_WRITE_DATA, 8'h5a);
      // read setup with read-ahead, then reads
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h00);
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h00);
      send_beat(vdphp_pkg::OP_READ_DATA, 8'h00);
      send_beat(vdphp_pkg::OP_READ_DATA, 8'hff);
      // mode register: switch to 16K addressing
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h80);
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h81);
      // address wrap at the top of VRAM
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'hfe);
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h7f);
      send_beat(vdphp_pkg::OP_WRITE_DATA, 8'h11);
      send_beat(vdphp_pkg::OP_WRITE_DATA, 8'h22);
      send_beat(vdphp_pkg::OP_WRITE_DATA, 8'h33);
      // register number past the bank is dropped
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h12);
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'hbf);
      // a data write between the two control bytes clears the flip-flop
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h55);
      send_beat(vdphp_pkg::OP_WRITE_DATA, 8'h44);
      // a status load between them leaves it alone
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'hfe);
      send_beat(vdphp_pkg::OP_LOAD_STATUS, 8'ha0);
      send_beat(vdphp_pkg::OP_WRITE_CTRL, 8'h3f);
      send_beat(vdphp_pkg::OP_READ_DATA, 8'h00);
      send_beat(vdphp_pkg::OP_READ_STATUS, 8'h00);
      send_beat(OP_SPARE_LAST, 8'hff);

      run_phase(PHASE_BEATS - beats_sent, 18, 72, 1'b0);
      run_phase(PHASE_BEATS, 72, 18, 1'b1);
      run_phase(PHASE_BEATS, 0, 0, 1'b0);
      wait_drained();

      $display("covered %0d host beats over three idle mixes and both addressing settings",
               beats_sent);
      $display("%0d data and status reads compared, %0d mismatches, %0d results left",
               reads_compared, mismatch_count, results_due);
      if (mismatch_count == 0 && results_due == 0)
         $display("video_display_processor_host_port_test OK");
      else
         $display("video_display_processor_host_port_test NOT OK");
      $finish;
   end

endmodule
